// File: hdl/stereo_fade_envelope_assert.svh
// assertion macros shared by the fade envelope rtl
`ifndef STEREO_FADE_ENVELOPE_ASSERT_SVH
`define STEREO_FADE_ENVELOPE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define SFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sfe_pkg.sv
// package with constants, register codes and sequencer types of the fade envelope
`timescale 1ns / 1ps

package sfe_pkg;

  localparam int COUNT_BITS_DEF     = 24;
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_IN_LEN  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_OUT_LEN = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL_FRAMES = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CHECK,
    ST_DIV_IN,
    ST_DIV_OUT,
    ST_MUL_G,
    ST_RND_G,
    ST_MUL_L,
    ST_MUL_R,
    ST_OUT
  } sfe_state_t;

  typedef enum logic [1:0] {
    MUL_GAINS,
    MUL_LEFT,
    MUL_RIGHT
  } sfe_mul_sel_t;

endpackage

// File: hdl/stereo_fade_envelope.sv
// One frame is processed at a time: a new frame is accepted only once the previous result
// has been loaded into the output registers. The sequencer uses one restoring divider,
// one quotient bit per cycle, run once per active fade, and one shared multiplier used
// for the gain product and both channels.
// Reset (synchronous, active high) clears the fade registers, the frame position, the
// sequencer and the result valid flag; a result request is held until taken.
`timescale 1ns / 1ps

`include "stereo_fade_envelope_assert.svh"

module stereo_fade_envelope #(
  parameter int COUNT_BITS     = sfe_pkg::COUNT_BITS_DEF,
  parameter int SAMPLE_BITS    = sfe_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = sfe_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [sfe_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [COUNT_BITS-1:0]                 cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         left_in,
  input  logic signed [SAMPLE_BITS-1:0]         right_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_BITS-1:0]         left_out,
  output logic signed [SAMPLE_BITS-1:0]         right_out,
  output logic                                  end_of_clip
);

  import sfe_pkg::*;

  localparam int F    = GAIN_FRAC_BITS;
  localparam int CB   = COUNT_BITS;
  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = ((SB > F + 1) ? SB : F + 1) + 1;
  localparam int PW   = AW + F + 2;
  localparam int CW   = $clog2(F);
  localparam logic [CW-1:0] DIV_LAST = CW'(F - 1);
  localparam logic [F:0] UNITY = {1'b1, {F{1'b0}}};
  localparam logic signed [PW-1:0] HALF_P = {{(PW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};

  sfe_state_t   state, state_next;
  sfe_mul_sel_t mul_sel;

  logic [CB-1:0] fade_in_len, fade_out_len, total_frames;
  logic [CB-1:0] frame_position;

  logic signed [SB-1:0] left_reg, right_reg, left_res;
  logic [CB-1:0] p, d, in_len, out_len;
  logic          zero_total, out_act_q, eoc_q;
  logic [CB-1:0] rem;
  logic [F-1:0]  quo;
  logic [CW-1:0] cnt;
  logic [F:0]    gin, gout, g;
  logic signed [PW-1:0] prod;

  logic          div_run, div_last, load_out;
  logic          in_act, out_act, eoc_next, pos_past;
  logic [CB-1:0] div_len, rem_next;
  logic [CB:0]   shifted, diff;
  logic          ge;
  logic [F-1:0]  quo_next;
  logic signed [AW-1:0]  mul_a;
  logic signed [F+1:0]   mul_b;
  logic signed [PW-1:0]  mul_res, rounded;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_in_len  <= '0;
      fade_out_len <= '0;
      total_frames <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FADE_IN_LEN:  fade_in_len  <= cfg_data;
        REG_FADE_OUT_LEN: fade_out_len <= cfg_data;
        REG_TOTAL_FRAMES: total_frames <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_SETUP;
      ST_SETUP:   state_next = ST_CHECK;
      ST_CHECK: begin
        if (in_act) state_next = ST_DIV_IN;
        else if (out_act) state_next = ST_DIV_OUT;
        else state_next = ST_MUL_G;
      end
      ST_DIV_IN: begin
        if (div_last) state_next = out_act_q ? ST_DIV_OUT : ST_MUL_G;
      end
      ST_DIV_OUT: if (div_last) state_next = ST_MUL_G;
      ST_MUL_G:   state_next = ST_RND_G;
      ST_RND_G:   state_next = ST_MUL_L;
      ST_MUL_L:   state_next = ST_MUL_R;
      ST_MUL_R:   state_next = ST_OUT;
      ST_OUT:     if (load_out) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    div_run  = 1'b0;
    load_out = 1'b0;
    mul_sel  = MUL_GAINS;
    unique case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_DIV_IN:  div_run  = 1'b1;
      ST_DIV_OUT: div_run  = 1'b1;
      ST_MUL_L:   mul_sel  = MUL_LEFT;
      ST_MUL_R:   mul_sel  = MUL_RIGHT;
      ST_OUT:     load_out = !out_valid || out_ready;
      default: ;
    endcase
    div_last = div_run && (cnt == DIV_LAST);
  end

  // position and span decisions
  always_comb begin
    pos_past = frame_position >= total_frames;
    in_act   = p < in_len;
    out_act  = d < out_len;
    eoc_next = !zero_total && (d == '0);
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    div_len  = (state == ST_DIV_IN) ? in_len : out_len;
    shifted  = {rem, 1'b0};
    diff     = shifted - {1'b0, div_len};
    ge       = shifted >= {1'b0, div_len};
    rem_next = ge ? diff[CB-1:0] : shifted[CB-1:0];
    quo_next = {quo[F-2:0], ge};
  end

  // shared multiplier and rounding
  always_comb begin
    unique case (mul_sel)
      MUL_GAINS: begin
        mul_a = $signed({{(AW - F - 1){1'b0}}, gin});
        mul_b = $signed({1'b0, gout});
      end
      MUL_LEFT: begin
        mul_a = $signed({{(AW - SB){left_reg[SB-1]}}, left_reg});
        mul_b = $signed({1'b0, g});
      end
      MUL_RIGHT: begin
        mul_a = $signed({{(AW - SB){right_reg[SB-1]}}, right_reg});
        mul_b = $signed({1'b0, g});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_res = PW'(mul_a) * PW'(mul_b);
    rounded = (prod + HALF_P) >>> F;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
    end else if (state == ST_CHECK) begin
      frame_position <= (zero_total || eoc_next) ? '0 : p + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          left_reg  <= left_in;
          right_reg <= right_in;
        end
      end
      ST_SETUP: begin
        p          <= pos_past ? '0 : frame_position;
        d          <= pos_past ? total_frames - 1'b1 : total_frames - 1'b1 - frame_position;
        in_len     <= (fade_in_len < total_frames) ? fade_in_len : total_frames;
        out_len    <= (fade_out_len < total_frames) ? fade_out_len : total_frames;
        zero_total <= total_frames == '0;
      end
      ST_CHECK: begin
        out_act_q <= out_act;
        eoc_q     <= eoc_next;
        cnt       <= '0;
        rem       <= in_act ? p : d;
        if (!in_act) gin <= UNITY;
        if (!out_act) gout <= UNITY;
      end
      ST_DIV_IN, ST_DIV_OUT: begin
        quo <= quo_next;
        if (div_last) begin
          cnt <= '0;
          if (state == ST_DIV_IN) begin
            gin <= {1'b0, quo_next};
            rem <= d;
          end else begin
            gout <= {1'b0, quo_next};
            rem  <= rem_next;
          end
        end else begin
          rem <= rem_next;
          cnt <= cnt + 1'b1;
        end
      end
      ST_MUL_G: prod <= mul_res;
      ST_RND_G: g <= rounded[F:0];
      ST_MUL_L: prod <= mul_res;
      ST_MUL_R: begin
        left_res <= rounded[SB-1:0];
        prod     <= mul_res;
      end
      ST_OUT: begin
        if (load_out) begin
          left_out    <= left_res;
          right_out   <= rounded[SB-1:0];
          end_of_clip <= eoc_q;
        end
      end
      default: ;
    endcase
  end

  `SFE_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == ST_SETUP && !in_ready, "request accepted but sequencer did not start")
  `SFE_ASSERT_NOW(a_rem_in, state == ST_DIV_IN, rem < in_len, "fade-in remainder not below divisor")
  `SFE_ASSERT_NOW(a_rem_out, state == ST_DIV_OUT, rem < out_len, "fade-out remainder not below divisor")
  `SFE_ASSERT_NOW(a_gain_unity, state == ST_MUL_G, gin <= UNITY && gout <= UNITY, "gain above unity")
  `SFE_ASSERT_NOW(a_eoc_wrap, load_out && eoc_q, frame_position == '0, "position did not wrap at end of clip")

endmodule

// File: dv/tb.sv
// testbench for stereo_fade_envelope: directed table, random clips, self-checking predictor
`timescale 1ns / 1ps

module tb;

  import sfe_pkg::*;

  localparam int CB = COUNT_BITS_DEF;
  localparam int SB = SAMPLE_BITS_DEF;
  localparam int GF = GAIN_FRAC_BITS_DEF;
  localparam longint unsigned UNITY = 64'd1 << GF;
  localparam longint unsigned HALF = 64'd1 << (GF - 1);
  localparam longint SMP_MAX = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SMP_MIN = -(64'sd1 <<< (SB - 1));
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam logic [CB-1:0] LEN_MAX = {CB{1'b1}};
  localparam int RANDOM_FRAMES = 1200;
  localparam int SQUEEZE_CYCLES = 400;

  typedef logic signed [SB-1:0] sample_t;

  typedef struct {
    sample_t left;
    sample_t right;
    logic    eoc;
  } frame_t;

  typedef struct {
    bit                        is_cfg;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CB-1:0]             val;
    sample_t                   left;
    sample_t                   right;
    bit                        known;
    frame_t                    want;
  } plan_row_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CB-1:0]             cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  sample_t                   left_in;
  sample_t                   right_in;
  logic                      out_valid;
  logic                      out_ready;
  sample_t                   left_out;
  sample_t                   right_out;
  logic                      end_of_clip;

  stereo_fade_envelope dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .left_in    (left_in),
    .right_in   (right_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .left_out   (left_out),
    .right_out  (right_out),
    .end_of_clip(end_of_clip)
  );

  logic [CB-1:0] fade_in_frames;
  logic [CB-1:0] fade_out_frames;
  logic [CB-1:0] clip_frames;
  logic [CB-1:0] position;

  frame_t    faded_frames[$];
  plan_row_t plan[$];

  int  errors = 0;
  int  frames_sent = 0;
  int  frames_seen = 0;
  int  clip_ends = 0;
  int  settings = 0;
  int  tx_quiet = 0;
  bit  squeeze = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  function automatic longint unsigned ramp_gain(input longint unsigned count,
                                                input longint unsigned len);
    if (len == 0 || count >= len) return UNITY;
    return (count << GF) / len;
  endfunction

  function automatic sample_t scale_sample(input sample_t s, input longint unsigned g);
    longint acc;
    acc = (longint'(s) * longint'(g) + longint'(HALF)) >>> GF;
    if (acc > SMP_MAX) acc = SMP_MAX;
    if (acc < SMP_MIN) acc = SMP_MIN;
    return acc[SB-1:0];
  endfunction

  function automatic frame_t fade_frame(input sample_t l, input sample_t r);
    frame_t f;
    longint unsigned p, tot, in_len, out_len, d, g;
    g = UNITY;
    f.eoc = 1'b0;
    tot = clip_frames;
    if (tot != 0) begin
      p = position;
      if (p >= tot) p = 0;
      in_len = (fade_in_frames < tot) ? fade_in_frames : tot;
      out_len = (fade_out_frames < tot) ? fade_out_frames : tot;
      d = tot - 1 - p;
      g = (ramp_gain(p, in_len) * ramp_gain(d, out_len) + HALF) >> GF;
      if (d == 0) begin
        f.eoc = 1'b1;
        position = '0;
      end else begin
        position = CB'(p + 1);
      end
    end else begin
      position = '0;
    end
    f.left = scale_sample(l, g);
    f.right = scale_sample(r, g);
    return f;
  endfunction

  function automatic int pick_gap();
    int sel;
    if (tx_quiet > 0) begin
      tx_quiet--;
      return 0;
    end
    sel = $urandom_range(0, 199);
    if (sel == 0) begin
      tx_quiet = $urandom_range(50, 200);
      return 0;
    end
    if (sel < 120) return 0;
    if (sel < 180) return $urandom_range(1, 3);
    if (sel < 194) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return sample_t'(SMP_MAX);
      1: return sample_t'(SMP_MIN);
      2: return sample_t'($urandom_range(0, 4)) - sample_t'(2);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CB-1:0] pick_total();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return '0;
    if (sel < 55) return CB'($urandom_range(1, 12));
    if (sel < 80) return CB'($urandom_range(13, 64));
    if (sel < 90) return LEN_MAX;
    return CB'($urandom);
  endfunction

  function automatic logic [CB-1:0] pick_len(input logic [CB-1:0] tot);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return '0;
    if (sel < 30) return LEN_MAX;
    if (sel < 45) return CB'(tot + $urandom_range(0, 2) - 1);
    if (sel < 85) return CB'($urandom_range(1, (tot < 64 ? tot : 64) + 2));
    return CB'($urandom);
  endfunction

  task automatic send_frame(input sample_t l, input sample_t r, input bit known,
                            input frame_t want);
    int gap;
    frame_t f;
    cfg_write <= 1'b0;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_in <= l;
    right_in <= r;
    do @(posedge clk); while (!in_ready);
    f = fade_frame(l, r);
    faded_frames.push_back(known ? want : f);
    frames_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    cfg_write <= 1'b0;
    while (faded_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CB-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_FADE_IN_LEN:  fade_in_frames = val;
      REG_FADE_OUT_LEN: fade_out_frames = val;
      REG_TOTAL_FRAMES: clip_frames = val;
      default: ;
    endcase
    settings++;
  endtask

  task automatic add_cfg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CB-1:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    plan.push_back(row);
  endtask

  task automatic add_frame(input sample_t l, input sample_t r, input bit known,
                           input sample_t wl, input sample_t wr, input logic weoc);
    plan_row_t row;
    row = '{default: '0};
    row.left = l;
    row.right = r;
    row.known = known;
    row.want = '{left: wl, right: wr, eoc: weoc};
    plan.push_back(row);
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    int hold;
    int quiet;
    int sel;
    out_ready = 1'b0;
    hold = 0;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (squeeze) begin
        squeeze = 1'b0;
        hold = SQUEEZE_CYCLES;
      end else if (hold == 0 && quiet > 0) begin
        quiet--;
      end else if (hold == 0) begin
        sel = $urandom_range(0, 199);
        if (sel == 0) quiet = $urandom_range(50, 200);
        else if (sel < 70) hold = $urandom_range(1, 3);
        else if (sel < 90) hold = $urandom_range(4, 12);
        else if (sel < 96) hold = $urandom_range(20, 60);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    frame_t want;
    if (!rst && out_valid && out_ready) begin
      frames_seen++;
      if (end_of_clip) clip_ends++;
      if (faded_frames.size() == 0) begin
        $display("%0t: unexpected frame, expected none, got left %0d right %0d eoc %0d",
                 $time, left_out, right_out, end_of_clip);
        errors++;
      end else begin
        want = faded_frames.pop_front();
        if (left_out !== want.left) begin
          $display("%0t: left_out expected %0d got %0d", $time, want.left, left_out);
          errors++;
        end
        if (right_out !== want.right) begin
          $display("%0t: right_out expected %0d got %0d", $time, want.right, right_out);
          errors++;
        end
        if (end_of_clip !== want.eoc) begin
          $display("%0t: end_of_clip expected %0d got %0d", $time, want.eoc, end_of_clip);
          errors++;
        end
      end
    end
  end

  initial begin
    plan_row_t row;
    frame_t none;
    logic [CB-1:0] tot;
    int n;
    int random_sent;
    int waited;
    bit squeezed;

    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_FADE_IN_LEN;
    cfg_data = '0;
    in_valid = 1'b0;
    left_in = '0;
    right_in = '0;
    fade_in_frames = '0;
    fade_out_frames = '0;
    clip_frames = '0;
    position = '0;
    none = '{left: '0, right: '0, eoc: 1'b0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty clip after reset: unity pass-through
    add_frame(16'sh7fff, 16'sh8000, 1, 16'sh7fff, 16'sh8000, 1'b0);
    add_frame(16'sh0000, 16'sh0000, 1, 16'sh0000, 16'sh0000, 1'b0);
    add_frame(-16'sd1, 16'sd1, 1, -16'sd1, 16'sd1, 1'b0);
    // short ramps in both directions
    add_cfg(REG_FADE_IN_LEN, 24'd2);
    add_cfg(REG_FADE_OUT_LEN, 24'd2);
    add_cfg(REG_TOTAL_FRAMES, 24'd4);
    add_frame(16'sh7fff, 16'sh8000, 1, 16'sh0000, 16'sh0000, 1'b0);
    add_frame(16'sh7fff, 16'sh8000, 0, '0, '0, 1'b0);
    add_frame(16'sh8000, 16'sh7fff, 0, '0, '0, 1'b0);
    add_frame(16'sh7fff, 16'sh8000, 1, 16'sh0000, 16'sh0000, 1'b1);
    // both fades disabled
    add_cfg(REG_FADE_IN_LEN, 24'd0);
    add_cfg(REG_FADE_OUT_LEN, 24'd0);
    add_cfg(REG_TOTAL_FRAMES, 24'd3);
    add_frame(16'sh7fff, 16'sh8000, 1, 16'sh7fff, 16'sh8000, 1'b0);
    add_frame(16'sh8000, 16'sh7fff, 1, 16'sh8000, 16'sh7fff, 1'b0);
    add_frame(16'sd1, -16'sd1, 1, 16'sd1, -16'sd1, 1'b1);
    // lengths clipped to the clip, both fades overlapping
    add_cfg(REG_FADE_IN_LEN, LEN_MAX);
    add_cfg(REG_FADE_OUT_LEN, LEN_MAX);
    add_frame(16'sh7fff, 16'sh8000, 0, '0, '0, 1'b0);
    add_frame(16'sh7fff, 16'sh8000, 0, '0, '0, 1'b0);
    add_frame(16'sh8000, 16'sh7fff, 0, '0, '0, 1'b0);
    // unknown register index is ignored
    add_cfg(REG_UNUSED, LEN_MAX);
    add_frame(16'sh5a5a, 16'sha5a5, 0, '0, '0, 1'b0);
    // clip shortened below the current position
    add_cfg(REG_TOTAL_FRAMES, 24'd8);
    repeat (4) add_frame(16'sh7fff, 16'sh8000, 0, '0, '0, 1'b0);
    add_cfg(REG_TOTAL_FRAMES, 24'd2);
    add_frame(16'sh7fff, 16'sh8000, 0, '0, '0, 1'b0);
    add_frame(16'sh4000, -16'sd3, 0, '0, '0, 1'b0);
    // one-frame clip
    add_cfg(REG_FADE_IN_LEN, 24'd0);
    add_cfg(REG_FADE_OUT_LEN, 24'd0);
    add_cfg(REG_TOTAL_FRAMES, 24'd1);
    add_frame(16'sh7fff, 16'sh8000, 1, 16'sh7fff, 16'sh8000, 1'b1);
    add_frame(16'sh8000, 16'sh0000, 1, 16'sh8000, 16'sh0000, 1'b1);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) wait_idle();
        write_reg(row.idx, row.val);
      end else begin
        send_frame(row.left, row.right, row.known, row.want);
      end
    end

    random_sent = 0;
    squeezed = 0;
    while (random_sent < RANDOM_FRAMES) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: write_reg(REG_TOTAL_FRAMES, pick_total());
        1: write_reg(REG_UNUSED, CB'($urandom));
        2: write_reg(REG_FADE_IN_LEN, pick_len(clip_frames));
        default: begin
          tot = pick_total();
          write_reg(REG_TOTAL_FRAMES, tot);
          write_reg(REG_FADE_IN_LEN, pick_len(tot));
          write_reg(REG_FADE_OUT_LEN, pick_len(tot));
        end
      endcase
      if (clip_frames == 0 || clip_frames > 64) n = $urandom_range(1, 40);
      else n = $urandom_range(1, (3 * clip_frames + 4 < 80) ? 3 * clip_frames + 4 : 80);
      if (!squeezed && random_sent >= 500) begin
        squeezed = 1;
        squeeze = 1'b1;
        n = 40;
      end
      repeat (n) begin
        send_frame(pick_sample(), pick_sample(), 0, none);
        random_sent++;
      end
    end

    in_valid <= 1'b0;
    cfg_write <= 1'b0;
    waited = 0;
    while (faded_frames.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    if (faded_frames.size() != 0) begin
      $display("%0t: %0d frames never came out", $time, faded_frames.size());
      errors++;
    end
    repeat (60) @(posedge clk);

    $display("covered %0d frames sent, %0d checked, %0d clip ends, %0d register writes",
             frames_sent, frames_seen, clip_ends, settings);
    $display("clips from empty to maximum length, ramps clipped, overlapping and disabled");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
